@@ rtl/srt_pkg.sv @@
// Shared constants of the sorted record table: sizes, opcodes and status codes.
package srt_pkg;

  localparam int DEPTH   = 64;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  localparam int KEY_W   = 16;
  localparam int SCORE_W = 15;
  localparam int SUM_W   = 21;
  localparam int OUT_CNT_W = 7;
  localparam int STEP_W  = $clog2(SUM_W);

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_COUNT   = 2'd1;
  localparam logic [1:0] OP_DELETE  = 2'd2;
  localparam logic [1:0] OP_AVERAGE = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

endpackage

@@ rtl/sorted_record_table.sv @@
// Sorted record table: key/score records in ascending key order held in RAM.
//
//   channel | direction | ports
//   --------+-----------+-----------------------------------------------------------
//   in      | input     | in_valid, in_stall, in_opcode, in_key, in_score
//   out     | output    | out_valid, out_stall, out_status, out_match_count,
//           |           | out_average_score, out_entries_held
//
// One operation is in flight at a time; each RAM step is a read state and an
// evaluate/write state. Insert moves records keyed at or above the new key up a
// slot from the top, then writes the new record; count scans all records; delete
// scans to the first match and shifts the rest down; average takes 21 quotient
// bits. Reset clears the state, fill count, score sum and out_valid, not the RAM.
// A new transfer is taken once the result is registered, even under out_stall.
module sorted_record_table
  import srt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_opcode,
  input  logic [KEY_W-1:0]     in_key,
  input  logic [SCORE_W-1:0]   in_score,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_status,
  output logic [OUT_CNT_W-1:0] out_match_count,
  output logic [SCORE_W-1:0]   out_average_score,
  output logic [OUT_CNT_W-1:0] out_entries_held
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS_RD  = 4'd1;
  localparam logic [3:0] S_INS_WR  = 4'd2;
  localparam logic [3:0] S_INS_PUT = 4'd3;
  localparam logic [3:0] S_CNT_RD  = 4'd4;
  localparam logic [3:0] S_CNT_EV  = 4'd5;
  localparam logic [3:0] S_DEL_RD  = 4'd6;
  localparam logic [3:0] S_DEL_EV  = 4'd7;
  localparam logic [3:0] S_SHF_RD  = 4'd8;
  localparam logic [3:0] S_SHF_WR  = 4'd9;
  localparam logic [3:0] S_DIV     = 4'd10;
  localparam logic [3:0] S_FIN     = 4'd11;

  // Record RAM.
  logic [KEY_W-1:0]   key_mem   [DEPTH];
  logic [SCORE_W-1:0] score_mem [DEPTH];
  logic [KEY_W-1:0]   rd_key_r;
  logic [SCORE_W-1:0] rd_score_r;
  logic [AW-1:0]      mem_rd_addr;
  logic               mem_we;
  logic [AW-1:0]      mem_wr_addr;
  logic [KEY_W-1:0]   mem_wr_key;
  logic [SCORE_W-1:0] mem_wr_score;

  logic [3:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     fill_r, fill_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [KEY_W-1:0]     key_r, key_nxt;
  logic [SCORE_W-1:0]   score_r, score_nxt;
  logic [1:0]           res_status_r, res_status_nxt;
  logic [CNT_W-1:0]     res_match_r, res_match_nxt;
  logic [SCORE_W-1:0]   res_avg_r, res_avg_nxt;
  logic [SUM_W-1:0]     quo_r, quo_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;

  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic [OUT_CNT_W-1:0] out_match_r;
  logic [SCORE_W-1:0]   out_avg_r;
  logic [OUT_CNT_W-1:0] out_held_r;

  logic [CNT_W-1:0] idx_p1;
  logic [CNT_W-1:0] idx_m1;
  logic [CNT_W-1:0] fill_m1;
  logic [CNT_W-1:0] cnt_now;
  logic [CNT_W:0]   trial;
  logic             q_bit;
  logic             in_xfer;
  logic             out_free;

  assign idx_p1   = idx_r + 1'b1;
  assign idx_m1   = idx_r - 1'b1;
  assign fill_m1  = fill_r - 1'b1;
  assign cnt_now  = cnt_r + CNT_W'(rd_key_r == key_r);
  assign trial    = {rem_r, quo_r[SUM_W-1]};
  assign q_bit    = (trial >= {1'b0, fill_r});
  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    fill_nxt       = fill_r;
    sum_nxt        = sum_r;
    key_nxt        = key_r;
    score_nxt      = score_r;
    res_status_nxt = res_status_r;
    res_match_nxt  = res_match_r;
    res_avg_nxt    = res_avg_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    step_nxt       = step_r;
    mem_rd_addr    = idx_r[AW-1:0];
    mem_we         = 1'b0;
    mem_wr_addr    = idx_r[AW-1:0];
    mem_wr_key     = key_r;
    mem_wr_score   = score_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          key_nxt        = in_key;
          score_nxt      = in_score;
          res_status_nxt = ST_OK;
          res_match_nxt  = '0;
          res_avg_nxt    = '0;
          cnt_nxt        = '0;
          idx_nxt        = '0;
          unique case (in_opcode)
            OP_INSERT: begin
              idx_nxt = fill_r;
              if (fill_r == CNT_W'(DEPTH)) begin
                res_status_nxt = ST_FULL;
                state_nxt      = S_FIN;
              end else if (fill_r == '0) begin
                state_nxt = S_INS_PUT;
              end else begin
                state_nxt = S_INS_RD;
              end
            end
            OP_COUNT: begin
              if (fill_r == '0) begin
                res_status_nxt = ST_NOT_FOUND;
                state_nxt      = S_FIN;
              end else begin
                state_nxt = S_CNT_RD;
              end
            end
            OP_DELETE: begin
              if (fill_r == '0) begin
                res_status_nxt = ST_EMPTY;
                state_nxt      = S_FIN;
              end else begin
                state_nxt = S_DEL_RD;
              end
            end
            default: begin
              if (fill_r == '0) begin
                res_status_nxt = ST_EMPTY;
                state_nxt      = S_FIN;
              end else begin
                quo_nxt   = sum_r;
                rem_nxt   = '0;
                step_nxt  = '0;
                state_nxt = S_DIV;
              end
            end
          endcase
        end
      end

      // Walk down from the top, moving every record whose key is not
      // smaller than the new key up by one slot.
      S_INS_RD: begin
        mem_rd_addr = idx_m1[AW-1:0];
        state_nxt   = S_INS_WR;
      end
      S_INS_WR: begin
        mem_we = 1'b1;
        if (rd_key_r >= key_r) begin
          mem_wr_key   = rd_key_r;
          mem_wr_score = rd_score_r;
          idx_nxt      = idx_m1;
          state_nxt    = (idx_m1 == '0) ? S_INS_PUT : S_INS_RD;
        end else begin
          fill_nxt  = fill_r + 1'b1;
          sum_nxt   = sum_r + SUM_W'(score_r);
          state_nxt = S_FIN;
        end
      end
      S_INS_PUT: begin
        mem_we    = 1'b1;
        fill_nxt  = fill_r + 1'b1;
        sum_nxt   = sum_r + SUM_W'(score_r);
        state_nxt = S_FIN;
      end

      S_CNT_RD: begin
        state_nxt = S_CNT_EV;
      end
      S_CNT_EV: begin
        if (idx_p1 == fill_r) begin
          res_match_nxt  = cnt_now;
          res_status_nxt = (cnt_now != '0) ? ST_OK : ST_NOT_FOUND;
          state_nxt      = S_FIN;
        end else begin
          cnt_nxt   = cnt_now;
          idx_nxt   = idx_p1;
          state_nxt = S_CNT_RD;
        end
      end

      S_DEL_RD: begin
        state_nxt = S_DEL_EV;
      end
      S_DEL_EV: begin
        if (rd_key_r == key_r) begin
          sum_nxt = sum_r - SUM_W'(rd_score_r);
          if (idx_p1 == fill_r) begin
            fill_nxt  = fill_m1;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_SHF_RD;
          end
        end else if (idx_p1 == fill_r) begin
          res_status_nxt = ST_NOT_FOUND;
          state_nxt      = S_FIN;
        end else begin
          idx_nxt   = idx_p1;
          state_nxt = S_DEL_RD;
        end
      end

      // Close the gap: move each record above the deleted one down a slot.
      S_SHF_RD: begin
        mem_rd_addr = idx_p1[AW-1:0];
        state_nxt   = S_SHF_WR;
      end
      S_SHF_WR: begin
        mem_we       = 1'b1;
        mem_wr_key   = rd_key_r;
        mem_wr_score = rd_score_r;
        idx_nxt      = idx_p1;
        if (idx_p1 == fill_m1) begin
          fill_nxt  = fill_m1;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_SHF_RD;
        end
      end

      // Restoring division, one quotient bit per cycle.
      S_DIV: begin
        rem_nxt  = q_bit ? CNT_W'(trial - {1'b0, fill_r}) : trial[CNT_W-1:0];
        quo_nxt  = {quo_r[SUM_W-2:0], q_bit};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(SUM_W - 1)) begin
          res_avg_nxt = quo_nxt[SCORE_W-1:0];
          state_nxt   = S_FIN;
        end
      end

      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[mem_wr_addr]   <= mem_wr_key;
      score_mem[mem_wr_addr] <= mem_wr_score;
    end
    rd_key_r   <= key_mem[mem_rd_addr];
    rd_score_r <= score_mem[mem_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      sum_r    <= sum_nxt;
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    cnt_r        <= cnt_nxt;
    key_r        <= key_nxt;
    score_r      <= score_nxt;
    res_status_r <= res_status_nxt;
    res_match_r  <= res_match_nxt;
    res_avg_r    <= res_avg_nxt;
    quo_r        <= quo_nxt;
    rem_r        <= rem_nxt;
    step_r       <= step_nxt;
    if (state_r == S_FIN && out_free) begin
      out_status_r <= res_status_r;
      out_match_r  <= OUT_CNT_W'(res_match_r);
      out_avg_r    <= res_avg_r;
      out_held_r   <= OUT_CNT_W'(fill_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_match_count   = out_match_r;
  assign out_average_score = out_avg_r;
  assign out_entries_held  = out_held_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(DEPTH))
    else $error("fill count exceeds table depth");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> idx_r <= fill_r)
    else $error("record write beyond the filled region");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> fill_r != '0)
    else $error("division started with an empty table");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_FULL |-> out_held_r == OUT_CNT_W'(DEPTH))
    else $error("full status reported while the table has room");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_EMPTY |-> out_held_r == '0)
    else $error("empty status reported while records are held");
`endif

endmodule

@@ verif/sorted_record_table_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the sorted record table: directed and random record operations.
module sorted_record_table_tb;
  import srt_pkg::*;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score;
  } record_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [OUT_CNT_W-1:0] match_count;
    logic [SCORE_W-1:0]   average_score;
    logic [OUT_CNT_W-1:0] entries_held;
  } outcome_t;

  localparam int SCORE_MAX = 25600;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_opcode = OP_AVERAGE;
  logic [KEY_W-1:0]     in_key = '0;
  logic [SCORE_W-1:0]   in_score = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_status;
  logic [OUT_CNT_W-1:0] out_match_count;
  logic [SCORE_W-1:0]   out_average_score;
  logic [OUT_CNT_W-1:0] out_entries_held;

  // Mirror of the table contents, kept in key order, and its running score sum.
  record_t          held_recs[$];
  logic [SUM_W-1:0] score_total = '0;
  outcome_t         pending_results[$];

  bit          idle_on;
  bit          draining;
  int unsigned stall_left;
  int unsigned error_count;
  int unsigned results_seen;
  int unsigned full_refusals;
  int unsigned empty_answers;
  int unsigned ops_done [4];

  always #10 clk = ~clk;

  sorted_record_table dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_key            (in_key),
    .in_score          (in_score),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_match_count   (out_match_count),
    .out_average_score (out_average_score),
    .out_entries_held  (out_entries_held)
  );

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= 40) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Applies one operation to the mirrored table and returns the result it must produce.
  function automatic outcome_t apply_to_records(input logic [1:0] op,
                                                input logic [KEY_W-1:0] key,
                                                input logic [SCORE_W-1:0] score);
    outcome_t res;
    record_t  rec;
    int       pos;
    int       hits;
    res = '0;
    res.status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (held_recs.size() >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // A new record goes in front of any records with an equal key.
          pos = 0;
          while (pos < held_recs.size() && held_recs[pos].key < key) pos++;
          rec.key = key;
          rec.score = score;
          held_recs.insert(pos, rec);
          score_total = score_total + score;
        end
      end
      OP_COUNT: begin
        hits = 0;
        foreach (held_recs[i]) if (held_recs[i].key == key) hits++;
        res.status = (hits != 0) ? ST_OK : ST_NOT_FOUND;
        res.match_count = OUT_CNT_W'(hits);
      end
      OP_DELETE: begin
        if (held_recs.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          pos = 0;
          while (pos < held_recs.size() && held_recs[pos].key != key) pos++;
          if (pos == held_recs.size()) begin
            res.status = ST_NOT_FOUND;
          end else begin
            score_total = score_total - held_recs[pos].score;
            held_recs.delete(pos);
          end
        end
      end
      OP_AVERAGE: begin
        if (held_recs.size() == 0) res.status = ST_EMPTY;
        else res.average_score = SCORE_W'(score_total / held_recs.size());
      end
    endcase
    res.entries_held = OUT_CNT_W'(held_recs.size());
    return res;
  endfunction

  // Sends one operation and records its expected result once the transfer happens.
  task automatic issue_op(input logic [1:0] op, input logic [KEY_W-1:0] key,
                          input logic [SCORE_W-1:0] score);
    outcome_t res;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_key    <= key;
    in_score  <= score;
    do @(posedge clk); while (in_stall);
    res = apply_to_records(op, key, score);
    pending_results.push_back(res);
    ops_done[op]++;
    if (res.status == ST_FULL) full_refusals++;
    if (res.status == ST_EMPTY) empty_answers++;
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return KEY_W'($urandom_range(0, 15));
    if (r < 7 && held_recs.size() != 0)
      return held_recs[$urandom_range(0, held_recs.size() - 1)].key;
    if (r == 7) return $urandom_range(0, 1) ? {KEY_W{1'b1}} : {KEY_W{1'b0}};
    return KEY_W'($urandom);
  endfunction

  function automatic logic [SCORE_W-1:0] pick_score();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return SCORE_W'(SCORE_MAX);
    return SCORE_W'($urandom_range(0, SCORE_MAX));
  endfunction

  function automatic logic [KEY_W-1:0] held_key();
    return held_recs[$urandom_range(0, held_recs.size() - 1)].key;
  endfunction

  // One random operation; the mix leans toward filling or toward draining so that
  // the table swings between empty and full.
  task automatic random_op();
    int unsigned      r;
    logic [KEY_W-1:0] key;
    if (held_recs.size() == DEPTH) draining = 1'b1;
    else if (held_recs.size() == 0) draining = 1'b0;
    else if ($urandom_range(0, 99) == 0) draining = !draining;
    r = $urandom_range(0, 99);
    key = pick_key();
    if (draining && held_recs.size() != 0 && $urandom_range(0, 6) != 0) key = held_key();
    if (!draining) begin
      if (r < 55) issue_op(OP_INSERT, key, pick_score());
      else if (r < 75) issue_op(OP_COUNT, key, pick_score());
      else if (r < 90) issue_op(OP_DELETE, key, pick_score());
      else issue_op(OP_AVERAGE, key, pick_score());
    end else begin
      if (r < 55) issue_op(OP_DELETE, key, pick_score());
      else if (r < 70) issue_op(OP_INSERT, key, pick_score());
      else if (r < 88) issue_op(OP_COUNT, key, pick_score());
      else issue_op(OP_AVERAGE, key, pick_score());
    end
  endtask

  task automatic test_empty_table();
    idle_on = 1'b1;
    issue_op(OP_AVERAGE, 16'h1234, '0);
    issue_op(OP_COUNT, 16'h1234, '0);
    issue_op(OP_DELETE, 16'h1234, '0);
    issue_op(OP_DELETE, '0, SCORE_W'(SCORE_MAX));
    wait_for_drain();
  endtask

  // Equal keys: the newest record sits first, so delete takes it and the average shows which.
  task automatic test_order_and_duplicates();
    idle_on = 1'b1;
    issue_op(OP_INSERT, 16'd100, '0);
    issue_op(OP_INSERT, 16'd100, SCORE_W'(SCORE_MAX));
    issue_op(OP_INSERT, 16'd7, 15'd1);
    issue_op(OP_INSERT, 16'd100, 15'd256);
    issue_op(OP_INSERT, 16'hFFFF, SCORE_W'(SCORE_MAX));
    issue_op(OP_INSERT, 16'h0000, 15'd12345);
    issue_op(OP_COUNT, 16'd100, '0);
    issue_op(OP_COUNT, 16'hFFFF, '0);
    issue_op(OP_COUNT, 16'h0000, '0);
    issue_op(OP_COUNT, 16'd99, '0);
    issue_op(OP_AVERAGE, '0, '0);
    issue_op(OP_DELETE, 16'd100, '0);
    issue_op(OP_AVERAGE, 16'hFFFF, 15'h7FFF);
    issue_op(OP_DELETE, 16'd99, '0);
    issue_op(OP_DELETE, 16'hFFFF, '0);
    issue_op(OP_DELETE, 16'h0000, '0);
    issue_op(OP_DELETE, 16'd7, '0);
    issue_op(OP_COUNT, 16'd100, '0);
    issue_op(OP_AVERAGE, '0, '0);
    issue_op(OP_DELETE, 16'd100, '0);
    issue_op(OP_DELETE, 16'd100, '0);
    issue_op(OP_COUNT, 16'd100, '0);
    issue_op(OP_AVERAGE, '0, '0);
    wait_for_drain();
  endtask

  task automatic test_fill_and_drain();
    idle_on = 1'b1;
    while (held_recs.size() < DEPTH) begin
      if ($urandom_range(0, 5) == 0) issue_op(OP_COUNT, pick_key(), pick_score());
      else issue_op(OP_INSERT, pick_key(), pick_score());
    end
    repeat (3) issue_op(OP_INSERT, pick_key(), pick_score());
    issue_op(OP_AVERAGE, pick_key(), pick_score());
    issue_op(OP_COUNT, held_key(), pick_score());
    while (held_recs.size() != 0) begin
      case ($urandom_range(0, 9))
        7: issue_op(OP_DELETE, pick_key(), pick_score());
        8, 9: issue_op(OP_COUNT, pick_key(), pick_score());
        default: issue_op(OP_DELETE, held_key(), pick_score());
      endcase
    end
    issue_op(OP_DELETE, pick_key(), pick_score());
    issue_op(OP_AVERAGE, pick_key(), pick_score());
    wait_for_drain();
  endtask

  task automatic test_random_mix(input int unsigned n_ops);
    for (int unsigned i = 0; i < n_ops; i++) begin
      // Every third stretch of operations runs with no idling at all.
      idle_on = ((i / 150) % 3) != 2;
      random_op();
      if (i % 400 == 399) wait_for_drain();
    end
    wait_for_drain();
  endtask

  task automatic test_quiet_tail(input int unsigned n_ops);
    idle_on = 1'b0;
    repeat (n_ops) random_op();
    in_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (stall_left == 0 && idle_on && $urandom_range(0, 9) == 0)
      stall_left = $urandom_range(1, 5);
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    outcome_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result arrived with no operation outstanding");
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
        if (out_match_count !== want.match_count)
          report_mismatch($sformatf("match count %0d, expected %0d",
                                    out_match_count, want.match_count));
        if (out_average_score !== want.average_score)
          report_mismatch($sformatf("average score %0d, expected %0d",
                                    out_average_score, want.average_score));
        if (out_entries_held !== want.entries_held)
          report_mismatch($sformatf("entries held %0d, expected %0d",
                                    out_entries_held, want.entries_held));
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_order_and_duplicates();
    test_fill_and_drain();
    test_random_mix(1300);
    test_quiet_tail(220);
    while (pending_results.size() != 0) @(posedge clk);
    // Any result beyond the expected ones would show up within one worst-case operation.
    repeat (2 * DEPTH + 40) @(posedge clk);
    $display("Ran %0d inserts, %0d counts, %0d deletes and %0d averages; %0d results checked.",
             ops_done[OP_INSERT], ops_done[OP_COUNT], ops_done[OP_DELETE],
             ops_done[OP_AVERAGE], results_seen);
    $display("Inserts refused on a full table: %0d; operations answered as empty: %0d.",
             full_refusals, empty_answers);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("Timeout with %0d results still outstanding.", pending_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
